// ===== rtl/hvd_pkg.sv =====
// Shared constants, types and lookup tables for the haversine distance pipeline.
package hvd_pkg;

  localparam longint unsigned COORD_SCALE = 64'd1000000;
  localparam longint unsigned FULL_TURN   = 64'd360 * COORD_SCALE;
  localparam longint unsigned HALF_TURN   = FULL_TURN / 64'd2;
  localparam longint unsigned QUARTER_TURN = FULL_TURN / 64'd4;

  // pi * 2^61, and the degree-to-radian factor for half-angle units
  localparam longint unsigned PI_Q61 = 64'h6487ED5110B4611A;
  localparam longint unsigned KH     = (PI_Q61 + FULL_TURN / 64'd2) / FULL_TURN;

  localparam int KH_LO_W = 18;
  localparam int KH_HI_W = 17;
  localparam logic [KH_LO_W-1:0] KH_LO = KH_LO_W'(KH);
  localparam logic [KH_HI_W-1:0] KH_HI = KH_HI_W'(KH >> KH_LO_W);

  localparam int LAT_W   = 28;
  localparam int LON_W   = 29;
  localparam int MAG_W   = 30;   // coordinate differences and magnitudes
  localparam int ANG_W   = 28;   // folded angle, at most half a turn
  localparam int THETA_W = 31;   // first-quadrant angle, Q1.30 radians
  localparam int CW      = 33;   // CORDIC datapath
  localparam int AW      = 61;   // a and 1-a, Q60 in [0, 1]
  localparam int RTW     = 31;   // square roots, Q30
  localparam int RADIUS_W = 23;
  localparam int DIST_W   = 33;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 40;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6372798;
  localparam logic [AW-1:0] ONE_Q60 = AW'(1) << 60;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic [THETA_W-1:0]   theta_t;
  typedef logic [AW-1:0]        aval_t;
  typedef logic [RTW-1:0]       root_t;

  localparam cval_t GAIN_START = cval_t'(652032874);

  function automatic cval_t atan_q30(input int unsigned idx);
    case (idx)
      0:  return cval_t'(843314857);
      1:  return cval_t'(497837829);
      2:  return cval_t'(263043836);
      3:  return cval_t'(133525159);
      4:  return cval_t'(67021687);
      5:  return cval_t'(33543516);
      6:  return cval_t'(16775851);
      7:  return cval_t'(8388437);
      8:  return cval_t'(4194283);
      9:  return cval_t'(2097149);
      default: return cval_t'(32'h4000_0000 >> idx);
    endcase
  endfunction

endpackage

// ===== rtl/hvd_angle.sv =====
// Angle front end: differences and latitudes, turn reduction, folding, latitude mirroring and degree-to-radian scaling.
module hvd_angle (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [hvd_pkg::LAT_W-1:0]  lat_a,
  input  logic signed [hvd_pkg::LON_W-1:0]  lon_a,
  input  logic signed [hvd_pkg::LAT_W-1:0]  lat_b,
  input  logic signed [hvd_pkg::LON_W-1:0]  lon_b,
  output logic                              out_valid,
  output hvd_pkg::theta_t                   theta [4],
  output logic [1:0]                        neg
);
  localparam int MW = hvd_pkg::MAG_W;
  localparam int GW = hvd_pkg::ANG_W;
  localparam int HW = GW + hvd_pkg::KH_HI_W;
  localparam int LW = GW + hvd_pkg::KH_LO_W;
  localparam int SW = HW + hvd_pkg::KH_LO_W;
  localparam logic [MW-1:0] FULL_M = MW'(hvd_pkg::FULL_TURN);
  localparam logic [MW-1:0] HALF_M = MW'(hvd_pkg::HALF_TURN);
  localparam logic [GW-1:0] HALF_G = GW'(hvd_pkg::HALF_TURN);
  localparam logic [GW-1:0] QUARTER_G = GW'(hvd_pkg::QUARTER_TURN);
  localparam logic [SW-1:0] RND = SW'(1) << 30;

  logic signed [MW-1:0] d_r [4];
  logic [MW-1:0]        m_r [4];
  logic [GW-1:0]        f_r [4];
  logic [GW-1:0]        g_r [4];
  logic [HW-1:0]        hi_r [4];
  logic [LW-1:0]        lo_r [4];
  hvd_pkg::theta_t      theta_r [4];
  logic [1:0]           negg_r, negh_r, negt_r;
  logic [5:0]           v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= MW'(lat_a) - MW'(lat_b);
      d_r[1] <= MW'(lon_a) - MW'(lon_b);
      d_r[2] <= MW'(lat_a);
      d_r[3] <= MW'(lat_b);
      for (int j = 0; j < 4; j++) begin
        // magnitude below two turns by the field widths: one subtract reduces it
        if (d_r[j][MW-1]) begin
          m_r[j] <= (MW'(-d_r[j]) >= FULL_M) ? MW'(-d_r[j]) - FULL_M : MW'(-d_r[j]);
        end else begin
          m_r[j] <= (d_r[j] >= FULL_M) ? d_r[j] - FULL_M : d_r[j];
        end
        f_r[j] <= (m_r[j] > HALF_M) ? GW'(FULL_M - m_r[j]) : GW'(m_r[j]);
        hi_r[j] <= {{hvd_pkg::KH_HI_W{1'b0}}, g_r[j]} * {{GW{1'b0}}, hvd_pkg::KH_HI};
        lo_r[j] <= {{hvd_pkg::KH_LO_W{1'b0}}, g_r[j]} * {{GW{1'b0}}, hvd_pkg::KH_LO};
        theta_r[j] <= hvd_pkg::THETA_W'(({hi_r[j], {hvd_pkg::KH_LO_W{1'b0}}}
                      + SW'(lo_r[j]) + RND) >> 31);
      end
      g_r[0] <= f_r[0];
      g_r[1] <= f_r[1];
      for (int j = 2; j < 4; j++) begin
        // latitude past a quarter turn: mirror it, cosine changes sign
        if (f_r[j] > QUARTER_G) begin
          g_r[j] <= (HALF_G - f_r[j]) << 1;
        end else begin
          g_r[j] <= f_r[j] << 1;
        end
        negg_r[j-2] <= f_r[j] > QUARTER_G;
      end
      negh_r <= negg_r;
      negt_r <= negh_r;
    end
  end

  assign out_valid = v_r[5];
  assign theta     = theta_r;
  assign neg       = negt_r;

endmodule

// ===== rtl/hvd_cordic_rot.sv =====
// Four-lane rotation CORDIC: half-angle sines and latitude cosines.
module hvd_cordic_rot (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  hvd_pkg::theta_t theta [4],
  input  logic [1:0]      neg,
  output logic            out_valid,
  output hvd_pkg::cval_t  s1,
  output hvd_pkg::cval_t  s2,
  output hvd_pkg::cval_t  c1,
  output hvd_pkg::cval_t  c2
);
  localparam int N  = hvd_pkg::CORDIC_STEPS;
  localparam int CW = hvd_pkg::CW;

  hvd_pkg::cval_t x_r [N+1][4];
  hvd_pkg::cval_t y_r [N+1][4];
  hvd_pkg::cval_t z_r [N+1][4];
  logic [1:0]     neg_r [N+1];
  logic [N:0]     v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        x_r[0][j] <= hvd_pkg::GAIN_START;
        y_r[0][j] <= '0;
        z_r[0][j] <= {{(CW-hvd_pkg::THETA_W){1'b0}}, theta[j]};
      end
      neg_r[0] <= neg;
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (!z_r[i][j][CW-1]) begin
            x_r[i+1][j] <= x_r[i][j] - (y_r[i][j] >>> i);
            y_r[i+1][j] <= y_r[i][j] + (x_r[i][j] >>> i);
            z_r[i+1][j] <= z_r[i][j] - hvd_pkg::atan_q30(i);
          end else begin
            x_r[i+1][j] <= x_r[i][j] + (y_r[i][j] >>> i);
            y_r[i+1][j] <= y_r[i][j] - (x_r[i][j] >>> i);
            z_r[i+1][j] <= z_r[i][j] + hvd_pkg::atan_q30(i);
          end
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign out_valid = v_r[N];
  assign s1 = y_r[N][0];
  assign s2 = y_r[N][1];
  assign c1 = neg_r[N][0] ? -x_r[N][2] : x_r[N][2];
  assign c2 = neg_r[N][1] ? -x_r[N][3] : x_r[N][3];

endmodule

// ===== rtl/hvd_arith.sv =====
// Products and sum forming a = sin^2(dlat/2) + cos*cos*sin^2(dlon/2), clamped, and 1 - a.
module hvd_arith (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hvd_pkg::cval_t s1,
  input  hvd_pkg::cval_t s2,
  input  hvd_pkg::cval_t c1,
  input  hvd_pkg::cval_t c2,
  output logic           out_valid,
  output hvd_pkg::aval_t a,
  output hvd_pkg::aval_t b
);
  localparam int CW = hvd_pkg::CW;
  localparam int PW = 34;
  localparam logic signed [63:0] RND = 64'sd1 <<< 29;
  localparam logic signed [64:0] ONE_S = 65'sd1 <<< 60;

  logic signed [2*CW-1:0]  cc_full, ss_full;
  logic signed [PW+CW-1:0] ps_full, qs_full;
  logic signed [63:0]      cc_rnd, ps_rnd;
  logic signed [64:0]      asum;

  logic signed [63:0] cc_r, ps_r, qs_r;
  logic signed [63:0] sq_r [5];
  logic signed [PW-1:0] p_r, q_r;
  hvd_pkg::cval_t s2_r [4];
  hvd_pkg::aval_t a_r, ao_r, bo_r;
  logic [6:0] v_r;

  always_comb begin
    cc_full = c1 * c2;
    ss_full = s1 * s1;
    cc_rnd  = cc_r + RND;
    ps_full = p_r * s2_r[1];
    ps_rnd  = ps_r + RND;
    qs_full = q_r * s2_r[3];
    asum    = {sq_r[4][63], sq_r[4]} + {qs_r[63], qs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r     <= cc_full[63:0];
      sq_r[0]  <= ss_full[63:0];
      s2_r[0]  <= s2;
      p_r      <= cc_rnd[63:30];
      sq_r[1]  <= sq_r[0];
      s2_r[1]  <= s2_r[0];
      ps_r     <= ps_full[63:0];
      sq_r[2]  <= sq_r[1];
      s2_r[2]  <= s2_r[1];
      q_r      <= ps_rnd[63:30];
      sq_r[3]  <= sq_r[2];
      s2_r[3]  <= s2_r[2];
      qs_r     <= qs_full[63:0];
      sq_r[4]  <= sq_r[3];
      // clamp a to [0, 1]
      if (asum[64]) begin
        a_r <= '0;
      end else if (asum > ONE_S) begin
        a_r <= hvd_pkg::ONE_Q60;
      end else begin
        a_r <= asum[hvd_pkg::AW-1:0];
      end
      ao_r <= a_r;
      bo_r <= hvd_pkg::ONE_Q60 - a_r;
    end
  end

  assign out_valid = v_r[6];
  assign a = ao_r;
  assign b = bo_r;

endmodule

// ===== rtl/hvd_isqrt.sv =====
// Two-lane pipelined floor square root, one result bit per stage.
module hvd_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hvd_pkg::aval_t a,
  input  hvd_pkg::aval_t b,
  output logic           out_valid,
  output hvd_pkg::root_t root_a,
  output hvd_pkg::root_t root_b
);
  localparam int N  = hvd_pkg::SQRT_STEPS;
  localparam int AW = hvd_pkg::AW;
  localparam int RW = AW + 1;

  hvd_pkg::aval_t val_r [N+1][2];
  logic [RW-1:0]  res_r [N+1][2];
  logic [RW-1:0]  bit_v [N];
  logic [RW-1:0]  trial [N][2];
  logic [N:0]     v_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      bit_v[i] = RW'(1) << (2 * (N - 1 - i));
      for (int j = 0; j < 2; j++) begin
        trial[i][j] = res_r[i][j] + bit_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r[0][0] <= a;
      val_r[0][1] <= b;
      res_r[0][0] <= '0;
      res_r[0][1] <= '0;
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (RW'(val_r[i][j]) >= trial[i][j]) begin
            val_r[i+1][j] <= val_r[i][j] - AW'(trial[i][j]);
            res_r[i+1][j] <= (res_r[i][j] >> 1) + bit_v[i];
          end else begin
            val_r[i+1][j] <= val_r[i][j];
            res_r[i+1][j] <= res_r[i][j] >> 1;
          end
        end
      end
    end
  end

  assign out_valid = v_r[N];
  assign root_a = res_r[N][0][hvd_pkg::RTW-1:0];
  assign root_b = res_r[N][1][hvd_pkg::RTW-1:0];

endmodule

// ===== rtl/hvd_cordic_vec.sv =====
// Vectoring CORDIC: half central angle atan2(sqrt a, sqrt(1-a)).
module hvd_cordic_vec (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hvd_pkg::root_t y_in,
  input  hvd_pkg::root_t x_in,
  output logic           out_valid,
  output hvd_pkg::cval_t angle
);
  localparam int N  = hvd_pkg::CORDIC_STEPS;
  localparam int CW = hvd_pkg::CW;

  hvd_pkg::cval_t x_r [N+1];
  hvd_pkg::cval_t y_r [N+1];
  hvd_pkg::cval_t z_r [N+1];
  logic [N:0]     v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= {{(CW-hvd_pkg::RTW){1'b0}}, x_in};
      y_r[0] <= {{(CW-hvd_pkg::RTW){1'b0}}, y_in};
      z_r[0] <= '0;
      for (int i = 0; i < N; i++) begin
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + hvd_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - hvd_pkg::atan_q30(i);
        end
      end
    end
  end

  assign out_valid = v_r[N];
  assign angle = z_r[N];

endmodule

// ===== rtl/haversine_distance_top.sv =====
// Top level of the haversine great-circle distance pipeline.
//
// Input channel (in_*): one transfer carries two points as signed
// millionths of a degree. Output channel (out_*): one transfer carries
// the great-circle distance in meters with 8 fraction bits, one result
// for every input transfer, in input order.
// Configuration channel (cfg_*): sets the sphere radius in whole meters;
// cfg_ready is always high. Write it only while no item is in flight.
//
// Throughput: one item per clock cycle while the output is not stalled.
// The pipeline is made of the front end, the 30-step rotation CORDIC,
// the products, the 31-step square root and the 30-step vectoring
// CORDIC, one step per stage, plus the final scaling and output register.
//
// Reset (rst_n low, synchronous) drops every item in flight, empties the
// output and restores the default radius of 6372798 m.
// When the receiver stalls and one more result arrives, it lands in a skid
// register and in_tready drops on the next cycle; the whole pipeline then
// holds until the skid register empties. Nothing is lost or repeated.
module haversine_distance_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // lat_a [27:0], lon_a [56:28], lat_b [84:57], lon_b [113:85], zero pad
  input  logic [hvd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // distance_q8 [32:0], zero pad
  output logic [hvd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hvd_pkg::RADIUS_W-1:0]       cfg_data
);
  localparam int CW = hvd_pkg::CW;
  localparam int DW = hvd_pkg::DIST_W;
  localparam int ZW = CW + 1;
  localparam int PW = hvd_pkg::RADIUS_W + ZW;
  localparam logic [PW-1:0] RND = PW'(1) << 21;

  logic signed [hvd_pkg::LAT_W-1:0] lat_a, lat_b;
  logic signed [hvd_pkg::LON_W-1:0] lon_a, lon_b;

  logic                en;
  logic                ang_v, rot_v, ari_v, sq_v, vec_v;
  hvd_pkg::theta_t     theta [4];
  logic [1:0]          neg;
  hvd_pkg::cval_t      s1, s2, c1, c2;
  hvd_pkg::aval_t      a_q, b_q;
  hvd_pkg::root_t      root_a, root_b;
  hvd_pkg::cval_t      angle;
  logic [ZW-1:0]       angle2;
  logic [PW-1:0]       dsum;

  logic [hvd_pkg::RADIUS_W-1:0] radius_r;
  logic [PW-1:0]       prod_r;
  logic [DW-1:0]       dist_r;
  logic [1:0]          fv_r;
  logic                out_v_r, skid_v_r;
  logic [DW-1:0]       out_d_r, skid_d_r;
  logic                out_load;

  // unpack the input transfer
  assign lat_a = in_tdata[27:0];
  assign lon_a = in_tdata[56:28];
  assign lat_b = in_tdata[84:57];
  assign lon_b = in_tdata[113:85];

  // advance the pipeline while the skid register is free
  assign en        = !skid_v_r;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= hvd_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  hvd_angle u_angle (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid),
    .lat_a, .lon_a, .lat_b, .lon_b,
    .out_valid(ang_v),
    .theta, .neg
  );

  hvd_cordic_rot u_rot (
    .clk, .rst_n, .en,
    .in_valid (ang_v),
    .theta, .neg,
    .out_valid(rot_v),
    .s1, .s2, .c1, .c2
  );

  hvd_arith u_arith (
    .clk, .rst_n, .en,
    .in_valid (rot_v),
    .s1, .s2, .c1, .c2,
    .out_valid(ari_v),
    .a        (a_q),
    .b        (b_q)
  );

  hvd_isqrt u_isqrt (
    .clk, .rst_n, .en,
    .in_valid (ari_v),
    .a        (a_q),
    .b        (b_q),
    .out_valid(sq_v),
    .root_a, .root_b
  );

  hvd_cordic_vec u_vec (
    .clk, .rst_n, .en,
    .in_valid (sq_v),
    .y_in     (root_a),
    .x_in     (root_b),
    .out_valid(vec_v),
    .angle
  );

  // full central angle; a negative residue counts as zero
  assign angle2 = angle[CW-1] ? '0 : {angle, 1'b0};
  assign dsum   = prod_r + RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[0], vec_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {{ZW{1'b0}}, radius_r} * {{hvd_pkg::RADIUS_W{1'b0}}, angle2};
      dist_r <= dsum[DW+21:22];
    end
  end

  // output register with a skid stage behind it
  assign out_load = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_load) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= fv_r[1];
      end
    end else if (fv_r[1] && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_d_r <= skid_v_r ? skid_d_r : dist_r;
    end else if (en) begin
      skid_d_r <= dist_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(hvd_pkg::OUT_TDATA_W-DW){1'b0}}, out_d_r};

endmodule

// ===== rtl/hvd_checker.sv =====
// Port-level checks for the haversine distance top level, with its bind.
module hvd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [hvd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // input backpressure only follows an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
      $past(rst_n) && !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output stall");

  // padding above the distance stays zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> out_tdata[hvd_pkg::OUT_TDATA_W-1:hvd_pkg::DIST_W] == '0)
    else $error("output padding not zero");

endmodule

bind haversine_distance_top hvd_checker u_hvd_checker (.*);

// ===== dv/haversine_distance_top_tb.sv =====
// Self-checking testbench for the haversine great-circle distance pipeline.
module haversine_distance_top_tb;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = 150;   // longer than the pipeline depth
  localparam int RANDOM_ITEMS  = 1300;

  localparam longint unsigned FULL_T    = 64'd360 * 64'd1000000;
  localparam longint unsigned HALF_T    = FULL_T / 2;
  localparam longint unsigned QUARTER_T = FULL_T / 4;
  localparam longint          Q60_ONE   = 64'sd1 <<< 60;

  // Q30 arctangents of 2^-i for the distance predictor
  localparam longint ARCTAN_Q30 [30] = '{
    843314857, 497837829, 263043836, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64,
    32, 16, 8, 4, 2
  };

  typedef struct {
    logic signed [hvd_pkg::LAT_W-1:0] lat_a;
    logic signed [hvd_pkg::LON_W-1:0] lon_a;
    logic signed [hvd_pkg::LAT_W-1:0] lat_b;
    logic signed [hvd_pkg::LON_W-1:0] lon_b;
  } point_pair_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [hvd_pkg::IN_TDATA_W-1:0]    in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [hvd_pkg::OUT_TDATA_W-1:0]   out_tdata;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [hvd_pkg::RADIUS_W-1:0]      cfg_data = '0;

  logic [hvd_pkg::DIST_W-1:0]        pending_distances [$];
  logic [hvd_pkg::RADIUS_W-1:0]      radius_m = hvd_pkg::RADIUS_RESET;
  int                                mismatches = 0;
  int                                cycle_count = 0;
  int                                send_idle_pct = 0;
  int                                recv_idle_pct = 0;

  haversine_distance_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Distance predictor
  // ---------------------------------------------------------------------

  // Fold a coordinate difference into [0, half turn].
  function automatic longint unsigned fold_angle(longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : longint'(d);
    m = m % FULL_T;
    if (m > HALF_T) m = FULL_T - m;
    return m;
  endfunction

  // Half-angle units to Q30 radians, rounded.
  function automatic longint half_units_to_q30(longint unsigned m);
    return longint'((m * hvd_pkg::KH + (64'd1 << 30)) >> 31);
  endfunction

  // Rotation-mode CORDIC; returns sine and cosine in Q30.
  function automatic void rotate_q30(input longint theta, output longint sin_q30,
                                     output longint cos_q30);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = theta;
    for (int i = 0; i < hvd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN_Q30[i];
      end
    end
    sin_q30 = y;
    cos_q30 = x;
  endfunction

  function automatic longint half_diff_sine(longint d);
    longint s, c;
    rotate_q30(half_units_to_q30(fold_angle(d)), s, c);
    return s;
  endfunction

  // Cosine of a latitude; keeps its sign past ninety degrees.
  function automatic longint latitude_cosine(longint lat);
    longint unsigned m;
    logic negative;
    longint s, c;
    m = fold_angle(lat);
    negative = m > QUARTER_T;
    if (negative) m = HALF_T - m;
    rotate_q30(half_units_to_q30(2 * m), s, c);
    return negative ? -c : c;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [hvd_pkg::DIST_W-1:0] great_circle_q8(point_pair_t p,
      logic [hvd_pkg::RADIUS_W-1:0] r);
    longint la, oa, lb, ob, s_lat, s_lon, c_a, c_b, cc, q, hav;
    longint x, y, z, dx, dy;
    longint unsigned dist_q8;
    la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
    s_lat = half_diff_sine(la - lb);
    s_lon = half_diff_sine(oa - ob);
    c_a = latitude_cosine(la);
    c_b = latitude_cosine(lb);
    cc  = (c_a * c_b + (64'sd1 <<< 29)) >>> 30;
    q   = (cc * s_lon + (64'sd1 <<< 29)) >>> 30;
    hav = s_lat * s_lat + q * s_lon;
    // clamp a into [0, 1] before the roots
    if (hav < 0) hav = 0;
    if (hav > Q60_ONE) hav = Q60_ONE;
    y = floor_sqrt(hav);
    x = floor_sqrt(Q60_ONE - hav);
    z = 0;
    for (int i = 0; i < hvd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN_Q30[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN_Q30[i];
      end
    end
    if (z < 0) z = 0;
    dist_q8 = (longint'(r) * longint'(2 * z) + (64'd1 << 21)) >> 22;
    return dist_q8[hvd_pkg::DIST_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Drivers and result checker
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Call at a falling edge; return at a falling edge with in_tvalid still high.
  task automatic send_pair(point_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, p.lon_b, p.lat_b, p.lon_a, p.lat_a};
    do @(posedge clk); while (!in_tready);
    pending_distances.push_back(great_circle_q8(p, radius_m));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_distances.size() != 0) @(negedge clk);
    // hold a full pipeline depth so nothing is in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_radius(logic [hvd_pkg::RADIUS_W-1:0] r);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = r;
    do @(posedge clk); while (!cfg_ready);
    radius_m = r;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver stall, re-drawn every cycle.
  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_distances.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d",
                                  out_tdata[hvd_pkg::DIST_W-1:0]));
      end else begin
        logic [hvd_pkg::DIST_W-1:0] want;
        want = pending_distances.pop_front();
        if (out_tdata[hvd_pkg::DIST_W-1:0] !== want)
          report_mismatch($sformatf("distance_q8 got %0d want %0d",
                                    out_tdata[hvd_pkg::DIST_W-1:0], want));
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic point_pair_t make_pair(longint la, longint oa, longint lb,
                                            longint ob);
    point_pair_t p;
    p.lat_a = la[hvd_pkg::LAT_W-1:0]; p.lon_a = oa[hvd_pkg::LON_W-1:0];
    p.lat_b = lb[hvd_pkg::LAT_W-1:0]; p.lon_b = ob[hvd_pkg::LON_W-1:0];
    return p;
  endfunction

  // Mostly valid coordinates; some near-antipodal pairs and raw field noise.
  function automatic point_pair_t random_pair();
    point_pair_t p;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      p = make_pair(longint'($urandom_range(180000000)) - 90000000,
                    longint'($urandom_range(360000000)) - 180000000,
                    longint'($urandom_range(180000000)) - 90000000,
                    longint'($urandom_range(360000000)) - 180000000);
    end else if (pick < 80) begin
      p = make_pair(longint'($urandom_range(180000000)) - 90000000,
                    longint'($urandom_range(360000000)) - 180000000, 0, 0);
      // mirror the first point, then nudge
      p = make_pair(p.lat_a, p.lon_a,
                    -longint'(p.lat_a) + $urandom_range(2000) - 1000,
                    longint'(p.lon_a) + 180000000 + $urandom_range(2000) - 1000);
    end else begin
      p.lat_a = hvd_pkg::LAT_W'($urandom); p.lon_a = hvd_pkg::LON_W'($urandom);
      p.lat_b = hvd_pkg::LAT_W'($urandom); p.lon_b = hvd_pkg::LON_W'($urandom);
    end
    return p;
  endfunction

  task automatic test_directed();
    point_pair_t list [$];
    list.push_back(make_pair(0, 0, 0, 0));
    list.push_back(make_pair(45000000, 9000000, 45000000, 9000000));
    list.push_back(make_pair(0, 0, 0, 1));
    list.push_back(make_pair(0, 0, 1, 0));
    list.push_back(make_pair(0, 0, 0, 180000000));                // antipodal
    list.push_back(make_pair(90000000, 0, -90000000, 0));         // pole to pole
    list.push_back(make_pair(90000000, 180000000, -90000000, -180000000));
    list.push_back(make_pair(-90000000, -180000000, 90000000, 180000000));
    list.push_back(make_pair(36120000, -86670000, 33940000, -118400000));
    list.push_back(make_pair(0, -180000000, 0, 180000000));
    list.push_back(make_pair(10000000, 0, -10000000, 180000000));
    // latitude past ninety degrees, field extremes
    list.push_back(make_pair(134217727, 0, 0, 0));
    list.push_back(make_pair(-134217728, 0, 0, 0));
    list.push_back(make_pair(134217727, 10, -134217728, 20));
    list.push_back(make_pair(100000000, 5000000, 95000000, -5000000));
    // longitude past range
    list.push_back(make_pair(0, 268435455, 0, -268435456));
    list.push_back(make_pair(20000000, 268435455, 20000000, 0));
    list.push_back(make_pair(-30000000, -268435456, 40000000, 200000000));
    list.push_back(make_pair(1, -1, -1, 1));
    list.push_back(make_pair(89999999, 179999999, -89999999, -179999999));
    foreach (list[i]) send_pair(list[i]);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  // Zero, one and the top end of the radius field.
  task automatic test_radius_extremes();
    logic [hvd_pkg::RADIUS_W-1:0] radii [3] = '{23'd1, 23'd8388607, 23'd0};
    foreach (radii[i]) begin
      write_radius(radii[i]);
      send_pair(make_pair(0, 0, 0, 180000000));
      send_pair(make_pair(90000000, 0, -90000000, 0));
      test_random(15);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // receiver idles more than sender
    send_idle_pct = 25; recv_idle_pct = 60;
    test_directed();
    test_radius_extremes();
    write_radius(23'd6378137);
    test_random(RANDOM_ITEMS / 3);

    // receiver mostly ready, sender sparse
    write_radius(hvd_pkg::RADIUS_W'($urandom_range(8388607, 1)));
    send_idle_pct = 60; recv_idle_pct = 25;
    test_random(RANDOM_ITEMS / 3);

    // back to back, no stalls
    write_radius(hvd_pkg::RADIUS_RESET);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(RANDOM_ITEMS / 3);

    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
